[src/assert_macros.svh]
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`endif

[src/sha_pkg.sv]
// Shared constants, types and round functions for the SHA-256 core.
// No dependencies.
`default_nettype none
package sha_pkg;
    localparam int WordWidth = 32;
    localparam int RoundCount = 64;
    localparam int LenPos = 56;

    typedef logic [WordWidth-1:0] word_t;

    localparam word_t RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } rnd_ctl_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordWidth - n));
    endfunction
endpackage
`default_nettype wire

[src/sha_round.sv]
// Shared round unit: one SHA-256 round and one schedule update per cycle while busy.
// Depends on sha_pkg.
`default_nettype none
module sha_round (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  sha_pkg::word_t      blk [16],
    input  sha_pkg::word_t      hin [8],
    output sha_pkg::word_t      vout [8],
    output sha_pkg::rnd_ctl_t   ctl
);
    import sha_pkg::*;

    word_t    w_reg [16];
    word_t    v_reg [8];
    logic [5:0] t_reg;
    logic     busy_reg;
    logic     done_reg;
    word_t    wt;
    word_t    wn;
    word_t    t1;
    word_t    t2;
    logic [3:0] i0;

    assign i0 = t_reg[3:0];

    always_comb
    begin
        wn = (rotr(w_reg[i0 - 4'd2], 17) ^ rotr(w_reg[i0 - 4'd2], 19)
              ^ (w_reg[i0 - 4'd2] >> 10)) + w_reg[i0 - 4'd7]
             + (rotr(w_reg[i0 - 4'd15], 7) ^ rotr(w_reg[i0 - 4'd15], 18)
              ^ (w_reg[i0 - 4'd15] >> 3)) + w_reg[i0];
        wt = t_reg[5:4] != 2'd0 ? wn : w_reg[i0];
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + RoundK[t_reg] + wt;
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            t_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                t_reg    <= '0;
            end
            else if (busy_reg)
            begin
                t_reg <= t_reg + 6'd1;
                if (t_reg == 6'(RoundCount - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            w_reg <= blk;
            v_reg <= hin;
        end
        else if (busy_reg)
        begin
            w_reg[i0] <= wt;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign vout = v_reg;
    assign ctl  = '{start: start, busy: busy_reg, done: done_reg};
endmodule
`default_nettype wire

[src/sha256_hash_core.sv]
// SHA-256 core: takes message words and runs one shared round unit, one round per
// cycle while a block is hashed. After a word is accepted, tready stays low while
// its valid bytes (at most four) go into the block; a word that completes a block
// also waits for the round unit to start, run 64 rounds and fold into the hash.
// After the last word come the 0x80 pad byte and zero and length bytes, filling
// one or two blocks to hash; eight digest words then leave one per accepted handshake.
// Depends on sha_pkg and sha_round.
`default_nettype none
module sha256_hash_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // data_word[31:0], valid_bytes[34:32], zero fill
    input  wire         s_tlast,   // last_of_message
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast    // last_word
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PUT  = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_PAD  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t     state_reg;
    word_t      blk_reg [16];
    word_t      h_reg [8];
    logic [63:0] len_reg;
    logic [5:0] fill_reg;
    logic [31:0] word_reg;
    logic [2:0] cnt_reg;
    logic       last_reg;
    logic       pad_reg;
    logic       tail_reg;
    logic [2:0] oidx_reg;
    logic [63:0] plen_reg;
    logic       start;
    word_t      vout [8];
    rnd_ctl_t   ctl;
    logic [7:0] pbyte;
    logic [2:0] nb;

    sha_round u_round (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .blk  (blk_reg),
        .hin  (h_reg),
        .vout (vout),
        .ctl  (ctl)
    );

    assign nb = s_tdata[34:32] > 3'd4 ? 3'd4 : s_tdata[34:32];
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {5'd0, oidx_reg, h_reg[oidx_reg]};
    assign m_tlast  = oidx_reg == 3'd7;

    always_comb
    begin
        if (state_reg == ST_PUT)
            pbyte = word_reg[31:24];
        else if (tail_reg && fill_reg >= 6'(LenPos))
            pbyte = plen_reg[63:56];
        else
            pbyte = 8'h00;
    end

    assign start = state_reg == ST_RUN && !ctl.busy && !ctl.done;

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_PUT && cnt_reg != 3'd0) || state_reg == ST_PAD)
            blk_reg[fill_reg[5:2]][8'(3 - fill_reg[1:0]) * 8 +: 8] <= pbyte;
        if (state_reg == ST_IDLE && s_tvalid && s_tlast)
            blk_reg[fill_reg[5:2]][8'(3 - fill_reg[1:0]) * 8 +: 8] <= 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg     <= InitHash;
            len_reg   <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            last_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            oidx_reg  <= '0;
            word_reg  <= '0;
            plen_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        word_reg  <= s_tdata[31:0];
                        cnt_reg   <= nb;
                        last_reg  <= s_tlast;
                        pad_reg   <= 1'b0;
                        len_reg   <= len_reg + 64'({nb, 3'd0});
                        state_reg <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    if (cnt_reg == 3'd0)
                    begin
                        if (last_reg)
                        begin
                            plen_reg  <= len_reg;
                            word_reg  <= 32'h8000_0000;
                            cnt_reg   <= 3'd1;
                            last_reg  <= 1'b0;
                            state_reg <= ST_PUT;
                            pad_reg   <= 1'b1;
                            tail_reg  <= fill_reg < 6'(LenPos);
                        end
                        else if (pad_reg)
                            state_reg <= ST_PAD;
                        else
                            state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        word_reg <= word_reg << 8;
                        cnt_reg  <= cnt_reg - 3'd1;
                        fill_reg <= fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                            state_reg <= ST_RUN;
                    end
                end
                ST_PAD:
                begin
                    if (tail_reg && fill_reg >= 6'(LenPos))
                        plen_reg <= plen_reg << 8;
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                        state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (ctl.done)
                    begin
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= h_reg[i] + vout[i];
                        if (pad_reg && tail_reg)
                            state_reg <= ST_OUT;
                        else if (pad_reg)
                        begin
                            tail_reg  <= 1'b1;
                            state_reg <= ST_PAD;
                        end
                        else
                            state_reg <= ST_PUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            h_reg     <= InitHash;
                            len_reg   <= '0;
                            fill_reg  <= '0;
                            pad_reg   <= 1'b0;
                            tail_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[src/sha_checker.sv]
// Port-level checker for sha256_hash_core, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sha_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast
);
    `CHK_IMPL(no_in_during_out, clk, rst_n, m_tvalid, !s_tready)
    `CHK_IMPL(last_on_seven, clk, rst_n, m_tvalid, m_tlast == (m_tdata[34:32] == 3'd7))
    `CHK_NEXT(index_advance, clk, rst_n, m_tvalid && m_tready && !m_tlast,
              m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
    `CHK_NEXT(idle_after_last, clk, rst_n, m_tvalid && m_tready && m_tlast, s_tready)
endmodule

bind sha256_hash_core sha_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

[sim/tb_top.sv]
// Testbench for sha256_hash_core: streams messages in, checks every digest word
// against a SHA-256 predictor kept in the scoreboard class. Depends on sha_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    typedef struct {
        word_t     digest;
        bit [2:0]  index;
        bit        last;
    } digest_t;

    class digest_board;
        word_t     chain [8];
        word_t     block [16];
        bit [63:0] bit_len;
        int        fill;
        digest_t   pending [$];
        int        errors;

        function new();
            chain = InitHash;
            foreach (block[i]) block[i] = '0;
            bit_len = '0;
            fill = 0;
            errors = 0;
        endfunction

        function void compress();
            word_t v [8];
            word_t sched [16];
            word_t w, t1, t2, a2, a15;
            sched = block;
            v = chain;
            for (int t = 0; t < RoundCount; t++)
            begin
                if (t >= 16)
                begin
                    a2 = sched[(t - 2) & 15];
                    a15 = sched[(t - 15) & 15];
                    sched[t & 15] = ({a2[16:0], a2[31:17]} ^ {a2[18:0], a2[31:19]}
                        ^ (a2 >> 10)) + sched[(t - 7) & 15]
                        + ({a15[6:0], a15[31:7]} ^ {a15[17:0], a15[31:18]} ^ (a15 >> 3))
                        + sched[t & 15];
                end
                w = sched[t & 15];
                t1 = v[7] + ({v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
                    ^ {v[4][24:0], v[4][31:25]}) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
                    + RoundK[t] + w;
                t2 = ({v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
                    ^ {v[0][21:0], v[0][31:22]})
                    + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            foreach (chain[i]) chain[i] += v[i];
            block = sched;
        endfunction

        function void put_byte(bit [7:0] b);
            block[fill >> 2][(3 - (fill & 3)) * 8 +: 8] = b;
            fill++;
            if (fill == 64)
            begin
                fill = 0;
                compress();
            end
        endfunction

        function void note_word(word_t data, bit [2:0] nbytes, bit last);
            int n;
            bit [63:0] len;
            digest_t d;
            n = (nbytes > 4) ? 4 : nbytes;
            for (int i = 0; i < n; i++)
            begin
                put_byte(data[31 - 8 * i -: 8]);
                bit_len += 8;
            end
            if (!last) return;
            len = bit_len;
            put_byte(8'h80);
            while (fill != LenPos) put_byte(8'h00);
            for (int i = 0; i < 8; i++) put_byte(len[63 - 8 * i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                d.digest = chain[i];
                d.index = 3'(i);
                d.last = (i == 7);
                pending.push_back(d);
            end
            chain = InitHash;
            bit_len = '0;
            fill = 0;
        endfunction

        function void check_word(word_t data, bit [2:0] index, bit last);
            digest_t d;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word %h", data));
                return;
            end
            d = pending.pop_front();
            if (data !== d.digest || index !== d.index || last !== d.last)
                report($sformatf("got %h/%0d/%0b want %h/%0d/%0b",
                    data, index, last, d.digest, d.index, d.last));
        endfunction

        function void report(string msg);
            $display("ERROR %0t: %s", $time, msg);
            errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    digest_board board = new();
    int send_idle;
    int recv_idle;
    int sent;

    sha256_hash_core u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("sha256_hash_core: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_word(word_t data, bit [2:0] nbytes, bit last);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, nbytes, data};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_word(data, nbytes, last);
        sent++;
    endtask

    task automatic send_message(int words, bit [2:0] tail);
        for (int i = 0; i < words; i++)
        begin
            if ($urandom_range(19) == 0)
                send_word($urandom, 3'($urandom_range(7)), 1'b0);
            else
                send_word($urandom, 3'd4, 1'b0);
        end
        send_word($urandom, tail, 1'b1);
    endtask

    task automatic run_phase(int count);
        int target;
        target = sent + count;
        while (sent < target)
        begin
            case ($urandom_range(3))
                0: send_message($urandom_range(0, 3), 3'($urandom_range(7)));
                1: send_message($urandom_range(12, 16), 3'($urandom_range(4)));
                default: send_message($urandom_range(0, 30), 3'($urandom_range(7)));
            endcase
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h61626300, 3'd3, 1'b1);
        send_word(32'hFFFFFFFF, 3'd7, 1'b1);
        send_word(32'hFFFFFFFF, 3'd5, 1'b0);
        send_word(32'h12345678, 3'd1, 1'b0);
        send_word(32'hA5A5A5A5, 3'd2, 1'b1);
        for (int i = 0; i < 13; i++) send_word(32'h5A5A5A5A, 3'd4, 1'b0);
        send_word(32'h01020304, 3'd4, 1'b1);
        send_message(15, 3'd4);
        send_idle = 34;
        recv_idle = 71;
        run_phase(100);
        send_idle = 71;
        recv_idle = 34;
        run_phase(100);
        send_idle = 0;
        recv_idle = 0;
        run_phase(100);
        s_tvalid <= 1'b0;
        waited = 0;
        while (board.pending.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("sha256_hash_core: match");
        else
            $display("sha256_hash_core: mismatch");
        $finish;
    end
endmodule
